### src/ptrd_pkg.sv
package ptrd_pkg;

   // configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   // register widths
   localparam int CFG_WIDTH   = 12;
   localparam int DELAY_WIDTH = 16;

   localparam logic [CFG_WIDTH-1:0]   BRAKE_THRESHOLD_RESET  = 12'd3000;
   localparam logic [DELAY_WIDTH-1:0] READY_DELAY_RESET      = 16'd2000;
   localparam logic [CFG_WIDTH-1:0]   ACCEL_ONE_OFFSET_RESET = 12'd2050;
   localparam logic [CFG_WIDTH-1:0]   ACCEL_TWO_OFFSET_RESET = 12'd1915;

   // result channel
   localparam int TORQUE_WIDTH = 7;
   localparam int PHASE_WIDTH  = 3;
   localparam int RSP_WIDTH    = 16;

   // q7.8 percentage scaling
   localparam int PCT_WIDTH      = 15;
   localparam int PCT_SUM_WIDTH  = 16;
   localparam int PCT_FRAC_SHIFT = 9;
   localparam int DIFF_WIDTH     = 10;

   localparam logic [PCT_WIDTH-1:0] PCT_MAX_Q8 = 15'd25600;
   localparam logic [PCT_WIDTH-1:0] PCT_MIN_Q8 = 15'd2048;

   // sensor one: d * 256 / 9, full scale reached above d = 900
   localparam logic [DIFF_WIDTH-1:0]      ONE_DIFF_LIMIT    = 10'd900;
   localparam int                         ONE_SCALED_WIDTH  = 18;
   localparam int                         ONE_RECIP_WIDTH   = 21;
   localparam logic [ONE_RECIP_WIDTH-1:0] ONE_RECIP         = 21'd1864136;
   localparam int                         ONE_RECIP_SHIFT   = 24;
   localparam int                         ONE_PROD_WIDTH    = 39;

   // sensor two: d * 5120 / 131, full scale reached above d = 655
   localparam logic [DIFF_WIDTH-1:0]      TWO_DIFF_LIMIT    = 10'd655;
   localparam int                         TWO_SCALED_WIDTH  = 22;
   localparam int                         TWO_RECIP_WIDTH   = 25;
   localparam logic [TWO_RECIP_WIDTH-1:0] TWO_RECIP         = 25'd32786010;
   localparam int                         TWO_RECIP_SHIFT   = 32;
   localparam int                         TWO_PROD_WIDTH    = 47;

   // torque shaping and latch thresholds
   localparam logic [TORQUE_WIDTH-1:0] TORQUE_DEADBAND    = 7'd10;
   localparam logic [TORQUE_WIDTH-1:0] TORQUE_KNEE        = 7'd90;
   localparam logic [TORQUE_WIDTH-1:0] TORQUE_FULL        = 7'd100;
   localparam logic [TORQUE_WIDTH-1:0] LATCH_SET_ABOVE    = 7'd25;
   localparam logic [TORQUE_WIDTH-1:0] LATCH_CLEAR_BELOW  = 7'd5;

   localparam int QUEUE_DEPTH = 2;

   // phase codes on the result channel
   localparam logic [PHASE_WIDTH-1:0] PHASE_BOOT          = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PHASE_WAIT_PRECHARGE = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PHASE_WAIT_START    = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PHASE_DELAY         = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PHASE_READY         = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PHASE_RUN           = 3'd5;

   typedef enum logic [1:0] {
      CSR_BRAKE_THRESHOLD  = 2'd0,
      CSR_READY_DELAY      = 2'd1,
      CSR_ACCEL_ONE_OFFSET = 2'd2,
      CSR_ACCEL_TWO_OFFSET = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]   brake_threshold;
      logic [DELAY_WIDTH-1:0] ready_delay_ms;
      logic [CFG_WIDTH-1:0]   accel_one_offset;
      logic [CFG_WIDTH-1:0]   accel_two_offset;
   } csr_regs_type;

   // what the front end hands to the sequencer for one sample
   typedef struct packed {
      logic [TORQUE_WIDTH-1:0] torque;
      logic                    brake_above;
      logic                    brake_below;
      logic                    precharge_ok;
      logic                    start_button;
   } sample_class_type;

   // result fields, torque in the lowest bits
   typedef struct packed {
      logic [PHASE_WIDTH-1:0]  phase;
      logic                    implausible_latched;
      logic                    inverter_cmd_valid;
      logic [TORQUE_WIDTH-1:0] torque_level;
   } rsp_fields_type;

   typedef enum logic [5:0] {
      SEQ_BOOT          = 6'b000001,
      SEQ_WAIT_PRECHARGE = 6'b000010,
      SEQ_WAIT_START    = 6'b000100,
      SEQ_DELAY         = 6'b001000,
      SEQ_READY         = 6'b010000,
      SEQ_RUN           = 6'b100000
   } seq_state_type;

endpackage

### src/ptrd_csr.sv
module ptrd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ptrd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [ptrd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [ptrd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output ptrd_pkg::csr_regs_type               regs
);
   import ptrd_pkg::*;

   csr_regs_type  regs_ff;
   csr_regs_type  regs_in;
   csr_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign regs       = regs_ff;

   always_comb begin
      unique case (index)
         CSR_BRAKE_THRESHOLD:  csr_prdata = CSR_DATA_WIDTH'(regs_ff.brake_threshold);
         CSR_READY_DELAY:      csr_prdata = CSR_DATA_WIDTH'(regs_ff.ready_delay_ms);
         CSR_ACCEL_ONE_OFFSET: csr_prdata = CSR_DATA_WIDTH'(regs_ff.accel_one_offset);
         CSR_ACCEL_TWO_OFFSET: csr_prdata = CSR_DATA_WIDTH'(regs_ff.accel_two_offset);
         default:              csr_prdata = '0;
      endcase
   end

   always_comb begin
      regs_in = regs_ff;
      if (write_en) begin
         unique case (index)
            CSR_BRAKE_THRESHOLD:  regs_in.brake_threshold  = csr_pwdata[CFG_WIDTH-1:0];
            CSR_READY_DELAY:      regs_in.ready_delay_ms   = csr_pwdata[DELAY_WIDTH-1:0];
            CSR_ACCEL_ONE_OFFSET: regs_in.accel_one_offset = csr_pwdata[CFG_WIDTH-1:0];
            CSR_ACCEL_TWO_OFFSET: regs_in.accel_two_offset = csr_pwdata[CFG_WIDTH-1:0];
            default:              regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.brake_threshold  <= BRAKE_THRESHOLD_RESET;
         regs_ff.ready_delay_ms   <= READY_DELAY_RESET;
         regs_ff.accel_one_offset <= ACCEL_ONE_OFFSET_RESET;
         regs_ff.accel_two_offset <= ACCEL_TWO_OFFSET_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

### src/ptrd_front.sv
module ptrd_front #(
   parameter int SAMPLE_WIDTH = 12,
   parameter int TIME_WIDTH   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [SAMPLE_WIDTH-1:0]         accel_one_raw,
   input  logic [SAMPLE_WIDTH-1:0]         accel_two_raw,
   input  logic [SAMPLE_WIDTH-1:0]         brake_raw,
   input  logic                            precharge_ok,
   input  logic                            start_button,
   input  logic [TIME_WIDTH-1:0]           now_ms,
   input  ptrd_pkg::csr_regs_type          regs,
   output logic                            push_valid,
   input  logic                            push_ready,
   output ptrd_pkg::sample_class_type      push_class,
   output logic [TIME_WIDTH-1:0]           push_now
);
   import ptrd_pkg::*;

   localparam int CMP_WIDTH = (SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH;

   // stage one: offset removal, clamp detect, reciprocal multiply
   logic [CMP_WIDTH-1:0]        a1_ext, a2_ext, brake_ext;
   logic [CMP_WIDTH-1:0]        off1_ext, off2_ext, thr_ext;
   logic [CMP_WIDTH-1:0]        d1, d2;
   logic                        d1_sat, d2_sat;
   logic [DIFF_WIDTH-1:0]       d1_lo, d2_lo;
   logic [ONE_SCALED_WIDTH-1:0] x1;
   logic [TWO_SCALED_WIDTH-1:0] x2;
   logic                        s1_load;
   logic                        s1_ready;

   logic                        s1_valid_ff, s1_valid_in;
   logic [ONE_PROD_WIDTH-1:0]   s1_prod1_ff;
   logic [TWO_PROD_WIDTH-1:0]   s1_prod2_ff;
   logic                        s1_sat1_ff, s1_sat2_ff;
   logic                        s1_brake_above_ff, s1_brake_below_ff;
   logic                        s1_pre_ff, s1_start_ff;
   logic [TIME_WIDTH-1:0]       s1_now_ff;

   // stage two: clamp, average, deadband
   logic [PCT_WIDTH-1:0]        p1, p2;
   logic [PCT_SUM_WIDTH-1:0]    pct_sum;
   logic [TORQUE_WIDTH-1:0]     avg;
   logic [TORQUE_WIDTH-1:0]     torque;
   logic                        s2_ready;
   sample_class_type            s2_class;

   logic                        s2_valid_ff, s2_valid_in;
   sample_class_type            s2_class_ff;
   logic [TIME_WIDTH-1:0]       s2_now_ff;

   assign a1_ext    = CMP_WIDTH'(accel_one_raw);
   assign a2_ext    = CMP_WIDTH'(accel_two_raw);
   assign brake_ext = CMP_WIDTH'(brake_raw);
   assign off1_ext  = CMP_WIDTH'(regs.accel_one_offset);
   assign off2_ext  = CMP_WIDTH'(regs.accel_two_offset);
   assign thr_ext   = CMP_WIDTH'(regs.brake_threshold);

   assign d1     = (a1_ext > off1_ext) ? (a1_ext - off1_ext) : '0;
   assign d2     = (a2_ext > off2_ext) ? (a2_ext - off2_ext) : '0;
   assign d1_sat = d1 > CMP_WIDTH'(ONE_DIFF_LIMIT);
   assign d2_sat = d2 > CMP_WIDTH'(TWO_DIFF_LIMIT);
   assign d1_lo  = d1_sat ? '0 : d1[DIFF_WIDTH-1:0];
   assign d2_lo  = d2_sat ? '0 : d2[DIFF_WIDTH-1:0];

   // d * 256 and d * 5120 by shifts
   assign x1 = {d1_lo, 8'b0};
   assign x2 = TWO_SCALED_WIDTH'({d2_lo, 12'b0}) + TWO_SCALED_WIDTH'({d2_lo, 10'b0});

   // bubble-collapsing handshake through both stages
   assign s2_ready = ~s2_valid_ff | push_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;
   assign s1_load  = in_valid & s1_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_prod1_ff       <= ONE_PROD_WIDTH'(x1) * ONE_PROD_WIDTH'(ONE_RECIP);
         s1_prod2_ff       <= TWO_PROD_WIDTH'(x2) * TWO_PROD_WIDTH'(TWO_RECIP);
         s1_sat1_ff        <= d1_sat;
         s1_sat2_ff        <= d2_sat;
         s1_brake_above_ff <= brake_ext > thr_ext;
         s1_brake_below_ff <= brake_ext < thr_ext;
         s1_pre_ff         <= precharge_ok;
         s1_start_ff       <= start_button;
         s1_now_ff         <= now_ms;
      end
   end

   assign p1 = s1_sat1_ff ? PCT_MAX_Q8 : s1_prod1_ff[ONE_RECIP_SHIFT +: PCT_WIDTH];
   assign p2 = s1_sat2_ff ? PCT_MAX_Q8 : s1_prod2_ff[TWO_RECIP_SHIFT +: PCT_WIDTH];

   assign pct_sum = PCT_SUM_WIDTH'(p1) + PCT_SUM_WIDTH'(p2);
   assign avg     = pct_sum[PCT_SUM_WIDTH-1:PCT_FRAC_SHIFT];

   always_comb begin
      if ((p1 > PCT_MIN_Q8) && (p2 > PCT_MIN_Q8)) begin
         torque = avg;
      end else begin
         torque = '0;
      end
      if (torque < TORQUE_DEADBAND) begin
         torque = '0;
      end else if (torque > TORQUE_KNEE) begin
         torque = TORQUE_FULL;
      end
   end

   always_comb begin
      s2_class.torque       = torque;
      s2_class.brake_above  = s1_brake_above_ff;
      s2_class.brake_below  = s1_brake_below_ff;
      s2_class.precharge_ok = s1_pre_ff;
      s2_class.start_button = s1_start_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_class_ff <= s2_class;
         s2_now_ff   <= s1_now_ff;
      end
   end

   assign push_valid = s2_valid_ff;
   assign push_class = s2_class_ff;
   assign push_now   = s2_now_ff;

endmodule

### src/ptrd_queue.sv
module ptrd_queue #(
   parameter int WIDTH = 43
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import ptrd_pkg::*;

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = count_ff < COUNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/ptrd_back.sv
module ptrd_back #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  ptrd_pkg::sample_class_type pop_class,
   input  logic [TIME_WIDTH-1:0]      pop_now,
   input  ptrd_pkg::csr_regs_type     regs,
   output logic                       out_valid,
   input  logic                       out_ready,
   output ptrd_pkg::rsp_fields_type   out_fields
);
   import ptrd_pkg::*;

   seq_state_type         state_ff, state_in;
   logic [TIME_WIDTH-1:0] start_time_ff, start_time_in;
   logic                  latch_ff, latch_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_fields_type        out_fields_ff, out_fields_in;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  delay_done;
   logic                  take;

   function automatic logic [PHASE_WIDTH-1:0] phase_code(input seq_state_type s);
      unique case (s)
         SEQ_BOOT:           return PHASE_BOOT;
         SEQ_WAIT_PRECHARGE: return PHASE_WAIT_PRECHARGE;
         SEQ_WAIT_START:     return PHASE_WAIT_START;
         SEQ_DELAY:          return PHASE_DELAY;
         SEQ_READY:          return PHASE_READY;
         SEQ_RUN:            return PHASE_RUN;
         default:            return PHASE_RUN;
      endcase
   endfunction

   assign pop_ready  = ~out_valid_ff | out_ready;
   assign take       = pop_valid & pop_ready;
   assign elapsed    = pop_now - start_time_ff;
   assign delay_done = elapsed >= TIME_WIDTH'(regs.ready_delay_ms);

   // brake plus throttle plausibility latch
   always_comb begin
      latch_in = latch_ff;
      if (pop_class.brake_above && (pop_class.torque > LATCH_SET_ABOVE)) begin
         latch_in = 1'b1;
      end else if (pop_class.brake_below && (pop_class.torque < LATCH_CLEAR_BELOW)) begin
         latch_in = 1'b0;
      end
   end

   // ready-to-drive sequencer
   always_comb begin
      state_in      = state_ff;
      start_time_in = start_time_ff;
      unique case (state_ff)
         SEQ_BOOT: begin
            state_in = pop_class.precharge_ok ? SEQ_WAIT_START : SEQ_WAIT_PRECHARGE;
         end
         SEQ_WAIT_PRECHARGE: begin
            if (pop_class.precharge_ok) begin
               state_in = SEQ_WAIT_START;
            end
         end
         SEQ_WAIT_START: begin
            if (pop_class.start_button && pop_class.brake_above) begin
               start_time_in = pop_now;
               state_in      = SEQ_DELAY;
            end
         end
         SEQ_DELAY: begin
            if (delay_done) begin
               state_in = SEQ_READY;
            end
         end
         SEQ_READY: begin
            state_in = SEQ_RUN;
         end
         SEQ_RUN: begin
            state_in = SEQ_RUN;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   always_comb begin
      out_fields_in.phase               = phase_code(state_in);
      out_fields_in.implausible_latched = latch_in;
      out_fields_in.inverter_cmd_valid  = state_ff == SEQ_RUN;
      out_fields_in.torque_level        = latch_in ? '0 : pop_class.torque;
   end

   assign out_valid_in = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_BOOT;
         start_time_ff <= '0;
         latch_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            state_ff      <= state_in;
            start_time_ff <= start_time_in;
            latch_ff      <= latch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_fields_ff <= out_fields_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_fields = out_fields_ff;

endmodule

### src/pedal_torque_ready_to_drive.sv
// channel   direction  transaction contents
// req_      in         one 10 ms sample: both pedal sensors, brake, precharge, start, time
// rsp_      out        torque percent, inverter command, latch state, phase
// csr_      in         register writes and reads, four registers at byte offsets 0, 4, 8, 12
//
// one sample is taken per clock while nothing downstream stalls; each result is registered in
// turn by the scaling multiply, averaging stage, queue and sequencer output register
// synchronous active-high reset returns registers to defaults and the sequencer to boot
// a stalled result does not stop sampling until the two-entry queue and both front
// stages are full
module pedal_torque_ready_to_drive #(
   parameter int SAMPLE_WIDTH = 12,
   parameter int TIME_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample transactions
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // accel_one_raw, accel_two_raw, brake_raw, precharge_ok, start_button, now_ms
   input  logic [((3*SAMPLE_WIDTH+2+TIME_WIDTH+7)/8)*8-1:0] req_tdata,
   // result transactions
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // torque_level, inverter_cmd_valid, implausible_latched, phase
   output logic [ptrd_pkg::RSP_WIDTH-1:0]      rsp_tdata,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptrd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [ptrd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [ptrd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ptrd_pkg::*;

   // bit positions of the sample fields in req_tdata
   localparam int A1_LSB    = 0;
   localparam int A2_LSB    = SAMPLE_WIDTH;
   localparam int BRAKE_LSB = 2 * SAMPLE_WIDTH;
   localparam int PRE_BIT   = 3 * SAMPLE_WIDTH;
   localparam int START_BIT = 3 * SAMPLE_WIDTH + 1;
   localparam int NOW_LSB   = 3 * SAMPLE_WIDTH + 2;

   localparam int ENTRY_WIDTH = $bits(sample_class_type) + TIME_WIDTH;

   csr_regs_type          regs;

   logic                  push_valid, push_ready;
   sample_class_type      push_class;
   logic [TIME_WIDTH-1:0] push_now;

   logic                  pop_valid, pop_ready;
   logic [ENTRY_WIDTH-1:0] pop_data;
   sample_class_type      pop_class;
   logic [TIME_WIDTH-1:0] pop_now;

   rsp_fields_type        rsp_fields;

   ptrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   // front end: offsets, q7.8 scaling, averaging, deadband, brake compares
   ptrd_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .accel_one_raw (req_tdata[A1_LSB +: SAMPLE_WIDTH]),
      .accel_two_raw (req_tdata[A2_LSB +: SAMPLE_WIDTH]),
      .brake_raw     (req_tdata[BRAKE_LSB +: SAMPLE_WIDTH]),
      .precharge_ok  (req_tdata[PRE_BIT]),
      .start_button  (req_tdata[START_BIT]),
      .now_ms        (req_tdata[NOW_LSB +: TIME_WIDTH]),
      .regs          (regs),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_class    (push_class),
      .push_now      (push_now)
   );

   // short queue decouples the front end from the sequencer
   ptrd_queue #(
      .WIDTH (ENTRY_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_class, push_now}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_class = sample_class_type'(pop_data[ENTRY_WIDTH-1:TIME_WIDTH]);
   assign pop_now   = pop_data[TIME_WIDTH-1:0];

   // back end: plausibility latch, ready-to-drive sequencer, result register
   ptrd_back #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_class  (pop_class),
      .pop_now    (pop_now),
      .regs       (regs),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_fields (rsp_fields)
   );

   // fields from bit 0 up, zero padded to whole bytes
   assign rsp_tdata = RSP_WIDTH'(rsp_fields);

endmodule

### src/ptrd_checker.sv
module ptrd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ptrd_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import ptrd_pkg::*;

   rsp_fields_type fields;

   assign fields = rsp_fields_type'(rsp_tdata[$bits(rsp_fields_type)-1:0]);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // latched implausibility forces zero torque
   a_latch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && fields.implausible_latched |-> fields.torque_level == '0)
      else $error("torque issued while implausibility latched");

   // torque is zero, inside the linear band, or full
   a_torque_band: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> fields.torque_level == '0 || fields.torque_level == TORQUE_FULL ||
                     (fields.torque_level >= TORQUE_DEADBAND &&
                      fields.torque_level <= TORQUE_KNEE))
      else $error("torque outside deadband and saturation shape");

   // an inverter command only comes from the run phase, which is never left
   a_cmd_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && fields.inverter_cmd_valid |-> fields.phase == PHASE_RUN)
      else $error("inverter command outside run phase");

endmodule

bind pedal_torque_ready_to_drive ptrd_checker u_ptrd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/pedal_torque_ready_to_drive_test.sv
module pedal_torque_ready_to_drive_test;
   import ptrd_pkg::*;

   // request packing: accel one, accel two, brake, precharge, start, time, padded to bytes
   localparam int SAMPLE_W = 12;
   localparam int TIME_W   = 32;
   localparam int REQ_W    = ((3*SAMPLE_W + 2 + TIME_W + 7) / 8) * 8;

   // q7.8 percentage limits used by the torque predictor
   localparam int unsigned PCT_CEIL_Q8  = 25600;
   localparam int unsigned PCT_FLOOR_Q8 = 2048;

   // long receiver hold-off, repeated through the run
   localparam int unsigned CHOKE_EVERY  = 2000;
   localparam int unsigned CHOKE_LENGTH = 300;

   // one sample transaction, first field in the lowest bits
   typedef struct packed {
      logic [TIME_W-1:0]   now_ms;
      logic                start_button;
      logic                precharge_ok;
      logic [SAMPLE_W-1:0] brake_raw;
      logic [SAMPLE_W-1:0] accel_two_raw;
      logic [SAMPLE_W-1:0] accel_one_raw;
   } sample_type;

   logic clock;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0]      rsp_tdata;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   pedal_torque_ready_to_drive dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // shadow of the register file, kept in step with every write
   logic [CFG_WIDTH-1:0]   cfg_brake_threshold = 12'd3000;
   logic [DELAY_WIDTH-1:0] cfg_ready_delay     = 16'd2000;
   logic [CFG_WIDTH-1:0]   cfg_one_zero        = 12'd2050;
   logic [CFG_WIDTH-1:0]   cfg_two_zero        = 12'd1915;

   // predicted sequencer and latch state, starting from the reset values
   logic [PHASE_WIDTH-1:0] pred_phase    = PHASE_BOOT;
   logic [TIME_W-1:0]      pred_start_ms = '0;
   logic                   pred_latch    = 1'b0;

   // samples waiting to be offered, each with the idle cycles that go before it
   sample_type     pending_samples[$];
   int unsigned    pending_gaps[$];
   rsp_fields_type rsp_expected[$];

   sample_type  req_current = '0;
   int unsigned req_hold = 0;
   int unsigned rsp_wait = 0;
   int unsigned rsp_count = 0;
   int unsigned queued_total = 0;
   int unsigned mismatch_count = 0;
   logic [TIME_W-1:0] sim_now = '0;

   int unsigned choke_left = 0;
   int unsigned choke_clock = 0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // pedal percentage in q7.8, fraction truncated, floored at zero, clamped to full scale
   function automatic logic [PCT_WIDTH-1:0] pedal_pct(input logic [SAMPLE_W-1:0] raw,
                                                        input logic [SAMPLE_W-1:0] zero,
                                                        input int unsigned num,
                                                        input int unsigned den);
      longint unsigned span;
      longint unsigned q;
      if (raw <= zero) return '0;
      span = raw - zero;
      q = span * num / den;
      if (q > PCT_CEIL_Q8) q = PCT_CEIL_Q8;
      return q[PCT_WIDTH-1:0];
   endfunction

   // torque shaping, latch and sequencer for one accepted sample
   task automatic predict_response(input sample_type s);
      logic [PCT_WIDTH-1:0]    pct_one;
      logic [PCT_WIDTH-1:0]    pct_two;
      logic [PCT_SUM_WIDTH-1:0] pct_sum;
      logic [TORQUE_WIDTH-1:0] torque;
      logic [TIME_W-1:0]       elapsed;
      logic                    cmd;
      rsp_fields_type          want;
      pct_one = pedal_pct(s.accel_one_raw, cfg_one_zero, 256, 9);
      pct_two = pedal_pct(s.accel_two_raw, cfg_two_zero, 25600, 655);
      pct_sum = pct_one + pct_two;
      torque = '0;
      // both sensors must agree the pedal is past eight percent
      if (pct_one > PCT_FLOOR_Q8 && pct_two > PCT_FLOOR_Q8)
         torque = TORQUE_WIDTH'(pct_sum >> 9);
      // deadband at the bottom, saturation at the top
      if (torque < 10) torque = '0;
      else if (torque > 90) torque = 7'd100;
      // brake equal to the threshold neither sets nor clears the latch
      if (s.brake_raw > cfg_brake_threshold && torque > 25) pred_latch = 1'b1;
      else if (s.brake_raw < cfg_brake_threshold && torque < 5) pred_latch = 1'b0;
      if (pred_latch) torque = '0;
      cmd = 1'b0;
      case (pred_phase)
         PHASE_BOOT: begin
            pred_phase = s.precharge_ok ? PHASE_WAIT_START : PHASE_WAIT_PRECHARGE;
         end
         PHASE_WAIT_PRECHARGE: begin
            if (s.precharge_ok) pred_phase = PHASE_WAIT_START;
         end
         PHASE_WAIT_START: begin
            if (s.start_button && s.brake_raw > cfg_brake_threshold) begin
               pred_start_ms = s.now_ms;
               pred_phase = PHASE_DELAY;
            end
         end
         PHASE_DELAY: begin
            // elapsed time wraps with the millisecond counter
            elapsed = s.now_ms - pred_start_ms;
            if (elapsed >= TIME_W'(cfg_ready_delay)) pred_phase = PHASE_READY;
         end
         PHASE_READY: begin
            pred_phase = PHASE_RUN;
         end
         default: begin
            cmd = 1'b1;
         end
      endcase
      want.torque_level        = torque;
      want.inverter_cmd_valid  = cmd;
      want.implausible_latched = pred_latch;
      want.phase               = pred_phase;
      rsp_expected.push_back(want);
   endtask

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
      if (v < 0) return '0;
      if (v > 4095) return 12'd4095;
      return SAMPLE_W'(v);
   endfunction

   // queue one sample; every fourth stretch of seventy goes out back to back
   task automatic queue_sample(input int a1, input int a2, input int b, input bit pre,
                               input bit start, input logic [TIME_W-1:0] now);
      sample_type s;
      s.accel_one_raw = clamp_sample(a1);
      s.accel_two_raw = clamp_sample(a2);
      s.brake_raw     = clamp_sample(b);
      s.precharge_ok  = pre;
      s.start_button  = start;
      s.now_ms        = now;
      pending_samples.push_back(s);
      pending_gaps.push_back(((queued_total / 70) % 4 == 3) ? 0 : $urandom_range(0, 9));
      queued_total++;
   endtask

   // mostly a plausible pedal pair around the offsets, with some disagreement and noise
   task automatic queue_random_sample();
      int unsigned pos;
      int unsigned pick;
      int a1;
      int a2;
      int b;
      pos = $urandom_range(0, 115);
      a1 = int'(cfg_one_zero) + int'(pos * 9) + int'($urandom_range(0, 16)) - 8;
      a2 = int'(cfg_two_zero) + int'(pos * 655 / 100) + int'($urandom_range(0, 16)) - 8;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         a1 = $urandom_range(0, 4095);
         a2 = $urandom_range(0, 4095);
      end else if (pick == 1) begin
         a2 = $urandom_range(0, 4095);
      end else if (pick == 2) begin
         a1 = int'(cfg_one_zero) - int'($urandom_range(0, 40));
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) b = $urandom_range(0, 4095);
      else if (pick < 4) b = int'(cfg_brake_threshold) + int'($urandom_range(0, 2)) - 1;
      else if (pick < 7) b = $urandom_range(0, cfg_brake_threshold);
      else b = $urandom_range(cfg_brake_threshold, 4095);
      // time moves in 10 ms steps with the odd jump, some of them across the wrap
      pick = $urandom_range(0, 49);
      if (pick == 0) sim_now = $urandom();
      else if (pick == 1) sim_now = 32'hFFFF_FFF0 + TIME_W'($urandom_range(0, 15));
      else sim_now = sim_now + 10;
      queue_sample(a1, a2, b, $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0, sim_now);
   endtask

   // register write: setup then access, random junk above the register width half the time
   task automatic csr_write(input csr_index_type idx, input logic [31:0] field);
      logic [31:0] word;
      int unsigned width;
      case (idx)
         CSR_READY_DELAY: width = DELAY_WIDTH;
         default:         width = CFG_WIDTH;
      endcase
      word = field;
      if ($urandom_range(0, 1) == 1) word = word | ($urandom() << width);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_BRAKE_THRESHOLD:  cfg_brake_threshold = word[CFG_WIDTH-1:0];
         CSR_READY_DELAY:      cfg_ready_delay     = word[DELAY_WIDTH-1:0];
         CSR_ACCEL_ONE_OFFSET: cfg_one_zero        = word[CFG_WIDTH-1:0];
         CSR_ACCEL_TWO_OFFSET: cfg_two_zero        = word[CFG_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // checked away from the clock edge so the driver's update of the same step has landed
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || rsp_expected.size() != 0);
      // let the pipeline settle before going on
      repeat (8) @(posedge clock);
   endtask

   task automatic run_setting(input int unsigned thr, input int unsigned delay,
                              input int unsigned one, input int unsigned two,
                              input int unsigned count);
      wait_idle();
      csr_write(CSR_BRAKE_THRESHOLD, thr);
      csr_write(CSR_READY_DELAY, delay);
      csr_write(CSR_ACCEL_ONE_OFFSET, one);
      csr_write(CSR_ACCEL_TWO_OFFSET, two);
      @(negedge clock);
      repeat (count) queue_random_sample();
   endtask

   // sender: offers the next sample after its idle cycles, predicts at each accept
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_hold = 0;
      end else begin
         if (req_tvalid && req_tready) predict_response(req_current);
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (req_hold < pending_gaps[0]) begin
               req_hold++;
               req_tvalid <= 1'b0;
            end else begin
               req_current = pending_samples.pop_front();
               void'(pending_gaps.pop_front());
               req_hold = 0;
               req_tdata  <= REQ_W'(req_current);
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // long hold-off on the result side, counted here so the sender keeps pushing
   always @(posedge clock) begin
      if (reset) begin
         choke_left  <= 0;
         choke_clock <= 0;
      end else begin
         choke_clock <= choke_clock + 1;
         if (choke_left != 0) choke_left <= choke_left - 1;
         else if (choke_clock % CHOKE_EVERY == CHOKE_EVERY / 2) choke_left <= CHOKE_LENGTH;
      end
   end

   // receiver: checks each result transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_fields_type)-1:0];
            if (rsp_expected.size() == 0) begin
               report_mismatch($sformatf("result 0x%h with nothing expected", rsp_tdata));
            end else begin
               want = rsp_expected.pop_front();
               if (got.torque_level !== want.torque_level)
                  report_mismatch($sformatf("torque_level got %0d want %0d",
                                            got.torque_level, want.torque_level));
               if (got.inverter_cmd_valid !== want.inverter_cmd_valid)
                  report_mismatch($sformatf("inverter_cmd_valid got %b want %b",
                                            got.inverter_cmd_valid, want.inverter_cmd_valid));
               if (got.implausible_latched !== want.implausible_latched)
                  report_mismatch($sformatf("implausible_latched got %b want %b",
                                            got.implausible_latched, want.implausible_latched));
               if (got.phase !== want.phase)
                  report_mismatch($sformatf("phase got %0d want %0d", got.phase, want.phase));
            end
            rsp_count++;
            // every third stretch of ninety results is taken with no random wait, hold-off apart
            rsp_wait = ((rsp_count / 90) % 3 == 2) ? 0 : $urandom_range(0, 9);
         end
         if (choke_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #5000000;
      $display("pedal_torque_ready_to_drive_test: FAIL");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk at reset settings: sensors, deadband, latch and the whole sequence
      // boot without precharge, then held in wait precharge with everything at full scale
      queue_sample(0, 0, 0, 0, 0, 32'h0000_0000);
      queue_sample(4095, 4095, 4095, 0, 1, 32'hFFFF_FFFF);
      // precharge arrives; pedals exactly at zero point, brake exactly at threshold holds latch
      queue_sample(2050, 1915, 3000, 1, 0, 32'h0000_0010);
      // brake just below and no torque clears the latch; start without brake is ignored
      queue_sample(2050, 1915, 2999, 0, 1, 32'h0000_0020);
      // brake pressed but no start; sensor one exactly at eight percent
      queue_sample(2122, 4095, 3001, 1, 0, 32'h0000_0030);
      // both just past eight percent, average still inside the deadband
      queue_sample(2123, 1968, 2000, 1, 0, 32'h0000_0040);
      // torque exactly ten, then nine
      queue_sample(2140, 1981, 0, 1, 0, 32'h0000_0050);
      queue_sample(2135, 1977, 0, 1, 0, 32'h0000_0060);
      // torque exactly ninety, then ninety one which saturates
      queue_sample(2860, 2505, 0, 1, 0, 32'h0000_0070);
      queue_sample(2870, 2512, 0, 1, 0, 32'h0000_0080);
      // braking with torque twenty five leaves the latch alone, twenty six sets it
      queue_sample(2275, 2079, 3001, 1, 0, 32'h0000_0090);
      queue_sample(2284, 2086, 4095, 1, 0, 32'h0000_00A0);
      // brake released but torque ten holds the latch
      queue_sample(2140, 1981, 0, 1, 0, 32'h0000_00B0);
      // sensor one beyond full scale, sensor two at zero: no torque, latch clears
      queue_sample(4095, 0, 0, 1, 0, 32'h0000_00C0);
      // start with brake pressed, timer taken just short of the wrap
      queue_sample(2500, 2300, 3001, 1, 1, 32'hFFFF_FF00);
      // one millisecond short of the delay, then exactly on it
      queue_sample(2500, 2300, 0, 1, 0, 32'h0000_06CF);
      queue_sample(2500, 2300, 0, 1, 0, 32'h0000_06D0);
      // ready goes to run, first command one sample later
      queue_sample(4095, 4095, 0, 0, 0, 32'h0000_06E0);
      queue_sample(4095, 4095, 0, 0, 0, 32'h0000_06F0);
      // sensors disagree while running
      queue_sample(4095, 1955, 0, 1, 1, 32'h0000_0700);
      sim_now = 32'h0000_0700;

      // extremes first, then random settings
      run_setting(0, 0, 0, 0, 150);
      run_setting(4095, 65535, 4095, 4095, 100);
      repeat (5) begin
         run_setting($urandom_range(0, 4095), $urandom_range(0, 65535),
                     $urandom_range(1500, 2600), $urandom_range(0, 4095) % 2 == 0 ?
                     $urandom_range(1400, 2500) : $urandom_range(0, 4095), 250);
      end

      wait_idle();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("pedal_torque_ready_to_drive_test: PASS");
      end else begin
         $display("pedal_torque_ready_to_drive_test: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
src/ptrd_pkg.sv
src/ptrd_csr.sv
src/ptrd_front.sv
src/ptrd_queue.sv
src/ptrd_back.sv
src/pedal_torque_ready_to_drive.sv
src/ptrd_checker.sv
tb/pedal_torque_ready_to_drive_test.sv
